// ===== sv/ttv_pkg.sv =====
// Shared types and constants of the triangle tangent vector block.
package ttv_pkg;

  localparam int unsigned IndexBits = 16;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned TexBits   = 16;
  localparam int unsigned TanBits   = 16;
  localparam int unsigned Q14One    = 16384;

  // One triangle corner as held by the front end
  typedef struct packed {
    logic        [IndexBits-1:0] idx;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
    logic signed [TexBits-1:0]   tex_u;
    logic signed [TexBits-1:0]   tex_v;
  } corner_t;

  // Core status towards the front end
  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  // Tangent result of one triangle
  typedef struct packed {
    logic signed [TanBits-1:0] tan_x;
    logic signed [TanBits-1:0] tan_y;
    logic signed [TanBits-1:0] tan_z;
    logic                      degen;
  } tan_res_t;

endpackage

// ===== sv/ttv_core.sv =====
// Sequenced tangent datapath: shared multiplier and shared subtractor.
module ttv_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                take_i,
  input  ttv_pkg::corner_t    c0_i,
  input  ttv_pkg::corner_t    c1_i,
  input  ttv_pkg::corner_t    c2_i,
  output ttv_pkg::core_stat_t stat_o,
  output ttv_pkg::tan_res_t   res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DIVI = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] st_q;
  logic [4:0] cnt_q;
  logic [1:0] ci_q;

  logic signed [16:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [16:0] e1_q [0:2];
  logic signed [16:0] e2_q [0:2];

  logic signed [35:0] first_q;
  logic signed [35:0] w_q [0:3];   // determinant then raw tangent
  logic        [34:0] m_q [0:2];
  logic        [2:0]  sg_q;
  logic               degen_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_q;

  logic [63:0] sum_q;
  logic [63:0] res_q;
  logic [63:0] bit_q;
  logic [31:0] rem_q;
  logic [15:0] num_q;
  logic [15:0] quo_q;
  logic signed [15:0] tan_q [0:2];

  logic [64:0] sub_a, sub_b, diff;
  logic        ge;
  logic [63:0] trial;
  logic [32:0] dtrial;
  logic [3:0]  km1;
  logic [34:0] orv;
  logic [45:0] numer;
  logic [15:0] qn, qc;
  logic        qneg;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_q == S_MUL) begin
      case (cnt_q[2:0])
        3'd0: begin mul_a = 32'(du1_q);   mul_b = 32'(dv2_q); end
        3'd1: begin mul_a = 32'(du2_q);   mul_b = 32'(dv1_q); end
        3'd2: begin mul_a = 32'(e1_q[0]); mul_b = 32'(dv2_q); end
        3'd3: begin mul_a = 32'(e2_q[0]); mul_b = 32'(dv1_q); end
        3'd4: begin mul_a = 32'(e1_q[1]); mul_b = 32'(dv2_q); end
        3'd5: begin mul_a = 32'(e2_q[1]); mul_b = 32'(dv1_q); end
        3'd6: begin mul_a = 32'(e1_q[2]); mul_b = 32'(dv2_q); end
        3'd7: begin mul_a = 32'(e2_q[2]); mul_b = 32'(dv1_q); end
        default: ;
      endcase
    end else if (st_q == S_SQ && cnt_q < 5'd3) begin
      mul_a = $signed({1'b0, m_q[cnt_q[1:0]][30:0]});
      mul_b = mul_a;
    end
  end
  assign prod = mul_a * mul_b;

  // shared subtractor: root step compare and divide step compare
  assign trial  = res_q + bit_q;
  assign dtrial = {rem_q, num_q[15]};
  always_comb begin
    if (st_q == S_SQRT) begin
      sub_a = {1'b0, sum_q};
      sub_b = {1'b0, trial};
    end else begin
      sub_a = 65'(dtrial);
      sub_b = 65'(res_q[31:0]);
    end
  end
  assign diff = sub_a - sub_b;
  assign ge   = ~diff[64];

  assign km1   = cnt_q[3:0] - 4'd1;
  assign orv   = m_q[0] | m_q[1] | m_q[2];
  assign numer = 46'({m_q[ci_q][30:0], 14'b0}) + 46'(res_q[31:1]);
  assign qn    = {quo_q[14:0], ge};
  assign qc    = (qn > 16'(ttv_pkg::Q14One)) ? 16'(ttv_pkg::Q14One) : qn;
  assign qneg  = sg_q[ci_q] & (qc != '0);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      ci_q  <= '0;
    end else begin
      case (st_q)
        S_IDLE: if (start_i) st_q <= S_DIFF;
        S_DIFF: begin
          st_q  <= S_MUL;
          cnt_q <= '0;
        end
        S_MUL: begin
          if (cnt_q == 5'd8) st_q <= S_CHK;
          else cnt_q <= cnt_q + 5'd1;
        end
        S_CHK: begin
          if (w_q[0] == '0 || (w_q[1] == '0 && w_q[2] == '0 && w_q[3] == '0))
            st_q <= S_DONE;
          else
            st_q <= S_NORM;
        end
        S_NORM: begin
          if (orv[34:31] == '0 && orv[30]) begin
            st_q  <= S_SQ;
            cnt_q <= '0;
          end
        end
        S_SQ: begin
          if (cnt_q == 5'd3) begin
            st_q  <= S_SQRT;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_SQRT: begin
          if (cnt_q == 5'd31) begin
            st_q <= S_DIVI;
            ci_q <= '0;
          end
          cnt_q <= cnt_q + 5'd1;
        end
        S_DIVI: begin
          st_q  <= S_DIV;
          cnt_q <= '0;
        end
        S_DIV: begin
          if (cnt_q == 5'd15) begin
            if (ci_q == 2'd2) begin
              st_q <= S_DONE;
            end else begin
              st_q <= S_DIVI;
              ci_q <= ci_q + 2'd1;
            end
          end
          cnt_q <= cnt_q + 5'd1;
        end
        S_DONE: if (take_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (st_q)
      S_DIFF: begin
        du1_q   <= 17'(c1_i.tex_u) - 17'(c0_i.tex_u);
        dv1_q   <= 17'(c1_i.tex_v) - 17'(c0_i.tex_v);
        du2_q   <= 17'(c2_i.tex_u) - 17'(c0_i.tex_u);
        dv2_q   <= 17'(c2_i.tex_v) - 17'(c0_i.tex_v);
        e1_q[0] <= 17'(c1_i.pos_x) - 17'(c0_i.pos_x);
        e1_q[1] <= 17'(c1_i.pos_y) - 17'(c0_i.pos_y);
        e1_q[2] <= 17'(c1_i.pos_z) - 17'(c0_i.pos_z);
        e2_q[0] <= 17'(c2_i.pos_x) - 17'(c0_i.pos_x);
        e2_q[1] <= 17'(c2_i.pos_y) - 17'(c0_i.pos_y);
        e2_q[2] <= 17'(c2_i.pos_z) - 17'(c0_i.pos_z);
      end
      // product pairs: first kept, second subtracted
      S_MUL: begin
        if (cnt_q != '0) begin
          if (!km1[0]) first_q <= prod_q[35:0];
          else w_q[km1[2:1]] <= first_q - $signed(prod_q[35:0]);
        end
      end
      S_CHK: begin
        degen_q <= (w_q[0] == '0) ||
                   (w_q[1] == '0 && w_q[2] == '0 && w_q[3] == '0);
        for (int i = 0; i < 3; i++) begin
          m_q[i]  <= w_q[i+1][35] ? 35'(-w_q[i+1]) : 35'(w_q[i+1]);
          sg_q[i] <= w_q[i+1][35] ^ w_q[0][35];
          tan_q[i] <= '0;
        end
      end
      // bring the largest magnitude's top bit to bit 30
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (orv[34:31] != '0) m_q[i] <= m_q[i] >> 1;
          else if (!orv[30]) m_q[i] <= m_q[i] << 1;
        end
        sum_q <= '0;
      end
      S_SQ: begin
        if (cnt_q != '0) sum_q <= sum_q + prod_q;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      // one result bit of the integer root a cycle
      S_SQRT: begin
        if (ge) begin
          sum_q <= diff[63:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DIVI: begin
        rem_q <= 32'(numer[45:16]);
        num_q <= numer[15:0];
        quo_q <= '0;
      end
      // one quotient bit a cycle, sign and clamp on the last
      S_DIV: begin
        rem_q <= ge ? diff[31:0] : dtrial[31:0];
        num_q <= num_q << 1;
        quo_q <= qn;
        if (cnt_q == 5'd15) tan_q[ci_q] <= qneg ? -$signed(qc) : $signed(qc);
      end
      default: ;
    endcase
  end

  assign stat_o.idle = (st_q == S_IDLE);
  assign stat_o.done = (st_q == S_DONE);
  assign res_o.tan_x = tan_q[0];
  assign res_o.tan_y = tan_q[1];
  assign res_o.tan_z = tan_q[2];
  assign res_o.degen = degen_q;

endmodule

// ===== sv/triangle_tangent_vector.sv =====
// Triangle tangent vector top level: corner holding, output register.
//
// Corners stream in on the in channel (valid/ready), one beat per corner.
// The first two corners of a triangle are held and accepted while the
// core is idle. The third starts the tangent computation; in_ready_o stays low
// until its result beat has been loaded into the output register.
// One result beat per triangle on the out channel: the three indices, the
// unit tangent in Q1.14 and a degenerate flag (tangent zero when set).
// After the third corner the core forms the products on a shared multiplier
// and normalises them with one-bit shifts, then runs a 32-step integer
// square root and three 16-step restoring divides on a shared subtractor.
// A degenerate triangle skips the normalising, root and divide steps and
// finishes with a zero tangent.
// When the receiver stalls, the result waits in the output register and
// the next triangle's first two corners are still taken; a third corner
// waits until the core has handed over its result.
// Reset clears the corner count and all valid flags.
module triangle_tangent_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] vertex_index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] tex_u_i,
  input  logic signed [15:0] tex_v_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] first_index_o,
  output logic [15:0] second_index_o,
  output logic [15:0] third_index_o,
  output logic signed [15:0] tangent_x_o,
  output logic signed [15:0] tangent_y_o,
  output logic signed [15:0] tangent_z_o,
  output logic        degenerate_o
);

  ttv_pkg::corner_t    held_q [0:2];
  ttv_pkg::corner_t    in_c;
  ttv_pkg::core_stat_t stat;
  ttv_pkg::tan_res_t   res;
  logic [1:0]          cnt_q;
  logic                in_acc, start, take, out_valid_q;

  assign in_c.idx   = vertex_index_i;
  assign in_c.pos_x = pos_x_i;
  assign in_c.pos_y = pos_y_i;
  assign in_c.pos_z = pos_z_i;
  assign in_c.tex_u = tex_u_i;
  assign in_c.tex_v = tex_v_i;

  assign in_ready_o = stat.idle;
  assign in_acc     = in_valid_i & in_ready_o;
  assign start      = in_acc & (cnt_q == 2'd2);
  assign take       = stat.done & (~out_valid_q | out_ready_i);

  // corner count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  // corner store
  always_ff @(posedge clk_i) begin
    if (in_acc) held_q[cnt_q] <= in_c;
  end

  ttv_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .take_i (take),
    .c0_i   (held_q[0]),
    .c1_i   (held_q[1]),
    .c2_i   (held_q[2]),
    .stat_o (stat),
    .res_o  (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      first_index_o  <= held_q[0].idx;
      second_index_o <= held_q[1].idx;
      third_index_o  <= held_q[2].idx;
      tangent_x_o    <= res.tan_x;
      tangent_y_o    <= res.tan_y;
      tangent_z_o    <= res.tan_z;
      degenerate_o   <= res.degen;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o) else $error("core did not leave idle after start");
  a_done_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !in_ready_o) else $error("input taken while result pending");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("corner count out of range");
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o) else $error("result lost on load");

endmodule
